// ===== hw/rtl/svfd_pkg.sv =====
// Shared constants, types and helper functions of the surface voxel face detector.
package svfd_pkg;

   // Largest grid the hardware is built for.
   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 64;

   // Field widths.
   localparam int SIZE_W  = 7;
   localparam int VOXEL_W = 8;
   localparam int POS_W   = 6;
   localparam int MASK_W  = 6;

   // Coordinate widths; the slice counter also holds size_z itself.
   localparam int X_W  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int Y_W  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int Z_W  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int ZC_W = $clog2(MAX_Z + 1);

   // Class store: three slice slots, each addressed by {y, x}.
   localparam int SLOT_W     = 2;
   localparam int RING_AW    = SLOT_W + Y_W + X_W;
   localparam int RING_DEPTH = 3 << (X_W + Y_W);
   localparam int CLASS_W    = 2;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register port.
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;

   // Raw voxel codes.
   localparam logic [VOXEL_W-1:0] VOXEL_SOLID = 8'd255;
   localparam logic [VOXEL_W-1:0] VOXEL_AIR   = 8'd0;

   // Face bits of the mask.
   localparam int FACE_XP = 0;
   localparam int FACE_XM = 1;
   localparam int FACE_YP = 2;
   localparam int FACE_YM = 3;
   localparam int FACE_ZP = 4;
   localparam int FACE_ZM = 5;

   // Input transaction kinds.
   localparam logic REQ_VOXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef enum logic [CLASS_W-1:0] {
      CLS_NEITHER = 2'd0,
      CLS_AIR     = 2'd1,
      CLS_SOLID   = 2'd2
   } class_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
      logic              rewind;
   } cfg_type;

   // One judged voxel with its neighbor classes and border flags.
   typedef struct packed {
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [Z_W-1:0]    z;
      logic [MASK_W-1:0] border;
      class_type         center;
      class_type         xp;
      class_type         xm;
      class_type         yp;
      class_type         ym;
      class_type         zp;
      class_type         zm;
   } job_type;

   // A written size of zero becomes one; a size above the maximum saturates.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int max);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (int'(v) > max) begin
         r = SIZE_W'(max);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/svfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module svfd_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/svfd_front.sv =====
// Front end: accepts voxel transactions, classifies them, keeps the class store and position.
module svfd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  svfd_pkg::cfg_type                 cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_kind,
   input  logic [svfd_pkg::VOXEL_W-1:0]      voxel_value,
   input  logic [svfd_pkg::QCNT_W-1:0]       queue_count,
   output logic                              push,
   output svfd_pkg::job_type                 push_job
);

   logic [svfd_pkg::X_W-1:0]    ix_ff, ix_in;
   logic [svfd_pkg::Y_W-1:0]    iy_ff, iy_in;
   logic [svfd_pkg::ZC_W-1:0]   iz_ff, iz_in;
   logic [svfd_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                        s1_valid_ff, s1_valid_in;
   svfd_pkg::job_type           s1_job_ff, s1_job_in;

   logic                        accept;
   logic                        is_voxel;
   logic                        in_volume;
   logic                        at_end;
   logic                        take;
   logic                        ring_we;
   logic                        judge;
   logic                        x_last;
   logic                        y_last;
   svfd_pkg::class_type         cls;
   logic [svfd_pkg::SLOT_W-1:0] jslot;
   logic [svfd_pkg::SLOT_W-1:0] pslot;
   logic [svfd_pkg::X_W-1:0]    ix_p1, ix_m1;
   logic [svfd_pkg::Y_W-1:0]    iy_p1, iy_m1;

   logic [svfd_pkg::RING_AW-1:0] wr_addr;
   logic [svfd_pkg::RING_AW-1:0] addr_center, addr_xp, addr_xm, addr_yp, addr_ym, addr_zm;
   logic [svfd_pkg::CLASS_W-1:0] rd_center, rd_xp, rd_xm, rd_yp, rd_ym, rd_zm;

   // Room is checked against the job already in flight through the RAM read.
   assign req_tready = (32'(queue_count) + 32'(s1_valid_ff)) < svfd_pkg::QUEUE_DEPTH;
   assign accept     = req_tvalid && req_tready;
   assign is_voxel   = (req_kind == svfd_pkg::REQ_VOXEL);
   assign in_volume  = 32'(iz_ff) < 32'(cfg.size_z);
   assign at_end     = 32'(iz_ff) == 32'(cfg.size_z);
   assign take       = accept && (is_voxel ? in_volume : at_end);
   assign ring_we    = accept && is_voxel && in_volume;
   assign judge      = take && (iz_ff != '0);
   assign x_last     = (32'(ix_ff) + 32'd1) == 32'(cfg.size_x);
   assign y_last     = (32'(iy_ff) + 32'd1) == 32'(cfg.size_y);

   assign ix_p1 = ix_ff + svfd_pkg::X_W'(1);
   assign ix_m1 = ix_ff - svfd_pkg::X_W'(1);
   assign iy_p1 = iy_ff + svfd_pkg::Y_W'(1);
   assign iy_m1 = iy_ff - svfd_pkg::Y_W'(1);

   always_comb begin
      case (voxel_value)
         svfd_pkg::VOXEL_SOLID: cls = svfd_pkg::CLS_SOLID;
         svfd_pkg::VOXEL_AIR:   cls = svfd_pkg::CLS_AIR;
         default:               cls = svfd_pkg::CLS_NEITHER;
      endcase
   end

   // The judged slice sits one slot behind the written one, its lower neighbor two.
   always_comb begin
      case (slot_ff)
         2'd0: begin
            jslot = 2'd2;
            pslot = 2'd1;
         end
         2'd1: begin
            jslot = 2'd0;
            pslot = 2'd2;
         end
         default: begin
            jslot = 2'd1;
            pslot = 2'd0;
         end
      endcase
   end

   assign wr_addr     = {slot_ff, iy_ff, ix_ff};
   assign addr_center = {jslot, iy_ff, ix_ff};
   assign addr_xp     = {jslot, iy_ff, ix_p1};
   assign addr_xm     = {jslot, iy_ff, ix_m1};
   assign addr_yp     = {jslot, iy_p1, ix_ff};
   assign addr_ym     = {jslot, iy_m1, ix_ff};
   assign addr_zm     = {pslot, iy_ff, ix_ff};

   svfd_ram #(.WIDTH(svfd_pkg::CLASS_W), .DEPTH(svfd_pkg::RING_DEPTH)) u_ring_center (
      .clock(clock), .wr_en(ring_we), .wr_addr(wr_addr), .wr_data(cls),
      .rd_addr(addr_center), .rd_data(rd_center)
   );
   svfd_ram #(.WIDTH(svfd_pkg::CLASS_W), .DEPTH(svfd_pkg::RING_DEPTH)) u_ring_xp (
      .clock(clock), .wr_en(ring_we), .wr_addr(wr_addr), .wr_data(cls),
      .rd_addr(addr_xp), .rd_data(rd_xp)
   );
   svfd_ram #(.WIDTH(svfd_pkg::CLASS_W), .DEPTH(svfd_pkg::RING_DEPTH)) u_ring_xm (
      .clock(clock), .wr_en(ring_we), .wr_addr(wr_addr), .wr_data(cls),
      .rd_addr(addr_xm), .rd_data(rd_xm)
   );
   svfd_ram #(.WIDTH(svfd_pkg::CLASS_W), .DEPTH(svfd_pkg::RING_DEPTH)) u_ring_yp (
      .clock(clock), .wr_en(ring_we), .wr_addr(wr_addr), .wr_data(cls),
      .rd_addr(addr_yp), .rd_data(rd_yp)
   );
   svfd_ram #(.WIDTH(svfd_pkg::CLASS_W), .DEPTH(svfd_pkg::RING_DEPTH)) u_ring_ym (
      .clock(clock), .wr_en(ring_we), .wr_addr(wr_addr), .wr_data(cls),
      .rd_addr(addr_ym), .rd_data(rd_ym)
   );
   svfd_ram #(.WIDTH(svfd_pkg::CLASS_W), .DEPTH(svfd_pkg::RING_DEPTH)) u_ring_zm (
      .clock(clock), .wr_en(ring_we), .wr_addr(wr_addr), .wr_data(cls),
      .rd_addr(addr_zm), .rd_data(rd_zm)
   );

   // Position counters: x fastest, then y, then the slice; rewind after the drain slice.
   always_comb begin
      ix_in   = ix_ff;
      iy_in   = iy_ff;
      iz_in   = iz_ff;
      slot_in = slot_ff;
      if (cfg.rewind) begin
         ix_in   = '0;
         iy_in   = '0;
         iz_in   = '0;
         slot_in = '0;
      end else if (take) begin
         if (x_last) begin
            ix_in = '0;
            if (y_last) begin
               iy_in = '0;
               if (at_end) begin
                  iz_in   = '0;
                  slot_in = '0;
               end else begin
                  iz_in   = iz_ff + svfd_pkg::ZC_W'(1);
                  slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
               end
            end else begin
               iy_in = iy_p1;
            end
         end else begin
            ix_in = ix_p1;
         end
      end
   end

   always_comb begin
      s1_valid_in                          = judge;
      s1_job_in                            = s1_job_ff;
      s1_job_in.x                          = ix_ff;
      s1_job_in.y                          = iy_ff;
      s1_job_in.z                          = svfd_pkg::Z_W'(iz_ff - svfd_pkg::ZC_W'(1));
      s1_job_in.border[svfd_pkg::FACE_XP]  = x_last;
      s1_job_in.border[svfd_pkg::FACE_XM]  = (ix_ff == '0);
      s1_job_in.border[svfd_pkg::FACE_YP]  = y_last;
      s1_job_in.border[svfd_pkg::FACE_YM]  = (iy_ff == '0);
      s1_job_in.border[svfd_pkg::FACE_ZP]  = at_end;
      s1_job_in.border[svfd_pkg::FACE_ZM]  = (32'(iz_ff) == 32'd1);
      s1_job_in.zp                         = cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ix_ff       <= '0;
         iy_ff       <= '0;
         iz_ff       <= '0;
         slot_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         ix_ff       <= ix_in;
         iy_ff       <= iy_in;
         iz_ff       <= iz_in;
         slot_ff     <= slot_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (judge) begin
         s1_job_ff <= s1_job_in;
      end
   end

   // The RAM read data arrives together with the registered job.
   always_comb begin
      push_job        = s1_job_ff;
      push_job.center = svfd_pkg::class_type'(rd_center);
      push_job.xp     = svfd_pkg::class_type'(rd_xp);
      push_job.xm     = svfd_pkg::class_type'(rd_xm);
      push_job.yp     = svfd_pkg::class_type'(rd_yp);
      push_job.ym     = svfd_pkg::class_type'(rd_ym);
      push_job.zm     = svfd_pkg::class_type'(rd_zm);
   end

   assign push = s1_valid_ff;

endmodule

// ===== hw/rtl/svfd_queue.sv =====
// Short job queue between the front end and the back end.
module svfd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  svfd_pkg::job_type           push_job,
   input  logic                        pop,
   output logic                        pop_valid,
   output svfd_pkg::job_type           pop_job,
   output logic [svfd_pkg::QCNT_W-1:0] count
);

   svfd_pkg::job_type           entry_ff [svfd_pkg::QUEUE_DEPTH];
   logic [svfd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [svfd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [svfd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == svfd_pkg::QPTR_W'(svfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + svfd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == svfd_pkg::QPTR_W'(svfd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + svfd_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + svfd_pkg::QCNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - svfd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== hw/rtl/svfd_back.sv =====
// Back end: builds the face mask of a judged voxel and holds the result for the output.
module svfd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  svfd_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata
);

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [23:0]                 rsp_data_ff;
   logic [svfd_pkg::MASK_W-1:0] mask;
   logic                        solid;
   logic                        hit;

   assign solid = (job.center == svfd_pkg::CLS_SOLID);

   // A face shows at the grid border or where the neighbor across it is air.
   always_comb begin
      mask                    = '0;
      mask[svfd_pkg::FACE_XP] = solid && (job.border[svfd_pkg::FACE_XP] ||
                                          job.xp == svfd_pkg::CLS_AIR);
      mask[svfd_pkg::FACE_XM] = solid && (job.border[svfd_pkg::FACE_XM] ||
                                          job.xm == svfd_pkg::CLS_AIR);
      mask[svfd_pkg::FACE_YP] = solid && (job.border[svfd_pkg::FACE_YP] ||
                                          job.yp == svfd_pkg::CLS_AIR);
      mask[svfd_pkg::FACE_YM] = solid && (job.border[svfd_pkg::FACE_YM] ||
                                          job.ym == svfd_pkg::CLS_AIR);
      mask[svfd_pkg::FACE_ZP] = solid && (job.border[svfd_pkg::FACE_ZP] ||
                                          job.zp == svfd_pkg::CLS_AIR);
      mask[svfd_pkg::FACE_ZM] = solid && (job.border[svfd_pkg::FACE_ZM] ||
                                          job.zm == svfd_pkg::CLS_AIR);
   end

   assign job_pop = job_valid && (!rsp_valid_ff || rsp_tready);
   assign hit     = job_pop && (mask != '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (job_pop) begin
         rsp_valid_in = (mask != '0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         rsp_data_ff <= {mask,
                         svfd_pkg::POS_W'(job.z),
                         svfd_pkg::POS_W'(job.y),
                         svfd_pkg::POS_W'(job.x)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/surface_voxel_face_detect.sv =====
// Top level of the surface voxel face detector: register port, front end, queue, back end.
//
//   Channel   Direction  Carries
//   req_*     in         voxel byte (tdata) and kind (tuser: 0 voxel, 1 drain)
//   rsp_*     out        coordinates and face mask of one surface voxel
//   csr_*     in/out     size_x, size_y, size_z registers at 0x0, 0x4, 0x8
//
// One transaction is accepted every cycle as long as the back end keeps up; the rate is
// set by the six class-store RAM copies, each serving one neighbor read per cycle.
// A result passes the RAM read, then the queue, then the output register. Reset is
// synchronous and clears only control state; the class store is never cleared, since an
// entry not yet written by the current volume is read only where a border flag decides the face.
// A stalled output holds its result while the front end keeps accepting until the
// four-entry queue, counting the job still in its RAM read, is full; only then does
// req_tready drop.
//
// Voxel transactions arrive in raster order, x fastest. The voxel one slice behind the
// input is judged, and a result is sent only when at least one of its faces is visible.
// After the last voxel, one slice of drain transactions flushes the final slice; drains
// before the end and voxels after it are dropped. A size register write rewinds the volume.
module surface_voxel_face_detect (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] voxel_value
   input  logic [0:0]                  req_tuser,   // [0] req_type

   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // [5:0] pos_x, [11:6] pos_y,
                                                    // [17:12] pos_z, [23:18] face_mask

   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [svfd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [svfd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [svfd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   logic [svfd_pkg::SIZE_W-1:0] size_x_ff, size_x_in;
   logic [svfd_pkg::SIZE_W-1:0] size_y_ff, size_y_in;
   logic [svfd_pkg::SIZE_W-1:0] size_z_ff, size_z_in;
   logic                        csr_write;
   logic                        csr_hit;
   logic [1:0]                  csr_index;
   logic [svfd_pkg::SIZE_W-1:0] wr_value;
   svfd_pkg::cfg_type           cfg;

   logic                        push;
   svfd_pkg::job_type           push_job;
   logic                        pop;
   logic                        pop_valid;
   svfd_pkg::job_type           pop_job;
   logic [svfd_pkg::QCNT_W-1:0] queue_count;

   // The register port never waits, so a write lands on its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];
   assign wr_value   = csr_pwdata[svfd_pkg::SIZE_W-1:0];

   // Only the three size registers exist; a write elsewhere changes nothing.
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      csr_hit   = 1'b0;
      if (csr_write) begin
         case (csr_index)
            svfd_pkg::REG_SIZE_X: begin
               size_x_in = svfd_pkg::clamp_size(wr_value, svfd_pkg::MAX_X);
               csr_hit   = 1'b1;
            end
            svfd_pkg::REG_SIZE_Y: begin
               size_y_in = svfd_pkg::clamp_size(wr_value, svfd_pkg::MAX_Y);
               csr_hit   = 1'b1;
            end
            svfd_pkg::REG_SIZE_Z: begin
               size_z_in = svfd_pkg::clamp_size(wr_value, svfd_pkg::MAX_Z);
               csr_hit   = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= svfd_pkg::clamp_size(svfd_pkg::SIZE_W'(64), svfd_pkg::MAX_X);
         size_y_ff <= svfd_pkg::clamp_size(svfd_pkg::SIZE_W'(64), svfd_pkg::MAX_Y);
         size_z_ff <= svfd_pkg::clamp_size(svfd_pkg::SIZE_W'(64), svfd_pkg::MAX_Z);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   always_comb begin
      case (csr_index)
         svfd_pkg::REG_SIZE_X: csr_prdata = svfd_pkg::CSR_DW'(size_x_ff);
         svfd_pkg::REG_SIZE_Y: csr_prdata = svfd_pkg::CSR_DW'(size_y_ff);
         svfd_pkg::REG_SIZE_Z: csr_prdata = svfd_pkg::CSR_DW'(size_z_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // The rewind travels with the write, so the counters restart at the same edge.
   assign cfg.size_x = size_x_ff;
   assign cfg.size_y = size_y_ff;
   assign cfg.size_z = size_z_ff;
   assign cfg.rewind = csr_hit;

   svfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser[0]),
      .voxel_value (req_tdata),
      .queue_count (queue_count),
      .push        (push),
      .push_job    (push_job)
   );

   svfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .count     (queue_count)
   );

   svfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
